// ----- rtl/lis_pkg.sv -----
package lis_pkg;

  // Table and field sizes
  localparam int MAX_LEN     = 256;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(MAX_LEN);
  localparam int LEN_W       = $clog2(MAX_LEN + 1);

  // Microprogram step addresses
  typedef logic [1:0] step_t;
  localparam step_t S_IDLE = 2'd0;  // wait for an input word
  localparam step_t S_TEST = 2'd1;  // search done? else read tail[mid]
  localparam step_t S_CMP  = 2'd2;  // narrow the search window
  localparam step_t S_DONE = 2'd3;  // write back, issue result

  // One control word of the sequencer ROM
  typedef struct packed {
    logic  wait_in;  // hold here until an input word is taken
    logic  chk;      // branch to jmp when lo >= hi, else read tail[mid]
    logic  cmp;      // compare read tail against the key
    logic  commit;   // update table and length, load result register
    step_t jmp;
    step_t nxt;
  } ucode_t;

  // Datapath controls for one cycle
  typedef struct packed {
    logic load;
    logic rd_en;
    logic cmp_en;
    logic commit;
  } ctrl_t;

  // Datapath status back to the sequencer
  typedef struct packed {
    logic             done;     // search window empty
    logic [LEN_W-1:0] len_nxt;  // length after this word
    logic             ovf_nxt;  // sticky overflow after this word
    logic             last;     // current word closes the sequence
    logic [LEN_W-1:0] len;      // stored length
  } stat_t;

  // Control store
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    w = '{wait_in: 1'b1, chk: 1'b0, cmp: 1'b0, commit: 1'b0, jmp: S_IDLE, nxt: S_TEST};
    case (s)
      S_IDLE: w = '{wait_in: 1'b1, chk: 1'b0, cmp: 1'b0, commit: 1'b0,
                    jmp: S_IDLE, nxt: S_TEST};
      S_TEST: w = '{wait_in: 1'b0, chk: 1'b1, cmp: 1'b0, commit: 1'b0,
                    jmp: S_DONE, nxt: S_CMP};
      S_CMP:  w = '{wait_in: 1'b0, chk: 1'b0, cmp: 1'b1, commit: 1'b0,
                    jmp: S_TEST, nxt: S_TEST};
      S_DONE: w = '{wait_in: 1'b0, chk: 1'b0, cmp: 1'b0, commit: 1'b1,
                    jmp: S_IDLE, nxt: S_IDLE};
      default: w = '{wait_in: 1'b1, chk: 1'b0, cmp: 1'b0, commit: 1'b0,
                     jmp: S_IDLE, nxt: S_TEST};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/lis_in_if.sv -----
interface lis_in_if import lis_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;
  logic                   last_item;

  modport source (output valid, value, last_item, input ready);
  modport sink   (input valid, value, last_item, output ready);
endinterface

// ----- rtl/lis_out_if.sv -----
interface lis_out_if import lis_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] lis_length;
  logic             sequence_end;
  logic             overflow;

  modport source (output valid, lis_length, sequence_end, overflow, input ready);
  modport sink   (input valid, lis_length, sequence_end, overflow, output ready);
endinterface

// ----- rtl/lis_length_tail_table.sv -----
// Longest strictly increasing subsequence length, patience-sorting table.
// in_i  : one word per sequence element (value, last_item), valid/ready.
// out_o : one word per input word (lis_length, sequence_end, overflow).
// Each element runs a binary search over the stored tails, driven by a
// four-step microprogram: a tail-table read and a compare per halving of
// the window, over a table of 256 entries. The next element can be taken
// in the idle step that follows the write-back. One element is in work
// at a time; in_i.ready is high only while the sequencer waits in its
// idle step.
// The result sits in an output register, so the next element is taken while
// it waits. If the receiver still holds off when the following result is
// due, the sequencer holds in its write-back step until the register frees.
// A word with last_item set reports its length and overflow, then clears
// both for the next sequence. Reset clears length, overflow and the output
// valid; the tail table is not cleared, as only written entries are read.
module lis_length_tail_table import lis_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  lis_in_if.sink    in_i,
  lis_out_if.source out_o
);

  step_t  step_q, step_d;
  ucode_t uw;
  ctrl_t  ctrl;
  stat_t  stat;
  logic   in_fire, out_busy, stall, branch;

  logic             out_valid_q;
  logic [LEN_W-1:0] out_len_q;
  logic             out_end_q, out_ovf_q;

  // Fetch control word
  assign uw = ucode_rom(step_q);

  assign in_i.ready = uw.wait_in;
  assign in_fire    = in_i.valid && uw.wait_in;
  assign out_busy   = out_valid_q && !out_o.ready;

  // Datapath controls
  assign ctrl = '{load:   in_fire,
                  rd_en:  uw.chk && !stat.done,
                  cmp_en: uw.cmp,
                  commit: uw.commit && !out_busy};

  // Sequencer next step
  always_comb begin
    stall  = (uw.wait_in && !in_i.valid) || (uw.commit && out_busy);
    branch = uw.chk && stat.done;
    if (stall) step_d = step_q;
    else if (branch) step_d = uw.jmp;
    else step_d = uw.nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) step_q <= S_IDLE;
    else step_q <= step_d;
  end

  lis_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .value_i     (in_i.value),
    .last_item_i (in_i.last_item),
    .stat_o      (stat)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (ctrl.commit) out_valid_q <= 1'b1;
    else if (out_o.ready) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.commit) begin
      out_len_q <= stat.len_nxt;
      out_end_q <= stat.last;
      out_ovf_q <= stat.ovf_nxt;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.lis_length   = out_len_q;
  assign out_o.sequence_end = out_end_q;
  assign out_o.overflow     = out_ovf_q;

  // Length never exceeds the table depth
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.len <= LEN_W'(MAX_LEN))
    else $error("length beyond table depth");

  // A new result appears only from a write-back
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctrl.commit))
    else $error("result without write-back");

  // Closing a sequence clears the length
  a_seq_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.commit && stat.last) |=> (stat.len == '0))
    else $error("length not cleared at sequence end");

  // Input is taken only in the idle step; a taken word starts the search
  a_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (step_q == S_TEST))
    else $error("search did not start after input");

endmodule

// ----- rtl/lis_datapath.sv -----
module lis_datapath import lis_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ctrl_t                  ctrl_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic                   last_item_i,
  output stat_t                  stat_o
);

  // Tail table: smallest tail per length, read data registered
  logic [VALUE_WIDTH-1:0] mem [MAX_LEN];
  logic [VALUE_WIDTH-1:0] rd_q;

  logic [VALUE_WIDTH-1:0] key_q;
  logic                   last_q;
  logic [LEN_W-1:0]       lo_q, lo_d, hi_q, hi_d, mid;
  logic                   eq_q, eq_d;
  logic [LEN_W-1:0]       len_q, len_d;
  logic                   ovf_q, ovf_d;
  logic                   skip, wr_en, extend;

  // Search window midpoint
  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  // Write-back decision: equal to tail before slot means no change
  assign skip   = (lo_q != '0) && eq_q;
  assign wr_en  = ctrl_i.commit && !skip && (lo_q != LEN_W'(MAX_LEN));
  assign extend = (lo_q == len_q);

  always_comb begin
    lo_d  = lo_q;
    hi_d  = hi_q;
    eq_d  = eq_q;
    len_d = len_q;
    ovf_d = ovf_q;
    if (ctrl_i.load) begin
      lo_d = '0;
      hi_d = len_q;
      eq_d = 1'b0;
    end else if (ctrl_i.cmp_en) begin
      if ($signed(rd_q) > $signed(key_q)) begin
        hi_d = mid;
      end else begin
        lo_d = mid + LEN_W'(1);
        eq_d = (rd_q == key_q);
      end
    end
    // new length and overflow for this word
    if (!skip) begin
      if (lo_q != LEN_W'(MAX_LEN)) begin
        if (extend) len_d = len_q + LEN_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      ovf_q <= 1'b0;
    end else if (ctrl_i.commit) begin
      len_q <= last_q ? '0 : len_d;
      ovf_q <= last_q ? 1'b0 : ovf_d;
    end
  end

  // Search registers
  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    eq_q <= eq_d;
    if (ctrl_i.load) begin
      key_q  <= value_i;
      last_q <= last_item_i;
    end
  end

  // Table port: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[lo_q[ADDR_W-1:0]] <= key_q;
    if (ctrl_i.rd_en) rd_q <= mem[mid[ADDR_W-1:0]];
  end

  assign stat_o = '{done: (lo_q >= hi_q), len_nxt: len_d, ovf_nxt: ovf_d,
                    last: last_q, len: len_q};

endmodule

// ----- tb/lis_length_checker.sv -----
// Watches both channels of the tail-table block, keeps its own copy of the
// tail table and predicts one result word per accepted input word.
module lis_length_checker import lis_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  lis_in_if    in_mon,
  lis_out_if   out_mon,
  output int   mismatch_count,
  output int   lengths_owed
);

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             seq_end;
    logic             ovf;
  } lis_result_t;

  // Shadow state: smallest tail per length, valid entries, sticky overflow
  logic signed [VALUE_WIDTH-1:0] tails [MAX_LEN];
  int unsigned                   run_len;
  logic                          run_ovf;
  lis_result_t                   owed_q [$];
  lis_result_t                   want;

  // Binary search for the first tail above v, then update the table
  function automatic lis_result_t place_in_tail_table(logic signed [VALUE_WIDTH-1:0] v,
                                                      logic closes);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lis_result_t r;
    lo = 0;
    hi = run_len;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (tails[mid] > v) begin
        hi = mid;
      end else begin
        lo = mid + 1;
      end
    end
    // an equal tail just below the slot leaves everything as it is
    if (!(lo > 0 && tails[lo - 1] == v)) begin
      if (lo < run_len) begin
        tails[lo] = v;
      end else if (run_len < MAX_LEN) begin
        tails[run_len] = v;
        run_len++;
      end else begin
        run_ovf = 1'b1;
      end
    end
    r.len     = run_len[LEN_W-1:0];
    r.seq_end = closes;
    r.ovf     = run_ovf;
    if (closes) begin
      run_len = 0;
      run_ovf = 1'b0;
    end
    return r;
  endfunction

  task automatic report(string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // Compare result words against the oldest prediction, queue new ones
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_len = 0;
      run_ovf = 1'b0;
      owed_q.delete();
      lengths_owed <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (owed_q.size() == 0) begin
          report($sformatf("result word with nothing owed, length %0d", out_mon.lis_length));
        end else begin
          want = owed_q.pop_front();
          if (out_mon.lis_length !== want.len)
            report($sformatf("lis_length %0d, expected %0d", out_mon.lis_length, want.len));
          if (out_mon.sequence_end !== want.seq_end)
            report($sformatf("sequence_end %b, expected %b", out_mon.sequence_end,
                             want.seq_end));
          if (out_mon.overflow !== want.ovf)
            report($sformatf("overflow %b, expected %b", out_mon.overflow, want.ovf));
        end
      end
      if (in_mon.valid && in_mon.ready)
        owed_q.insert(owed_q.size(), place_in_tail_table(in_mon.value, in_mon.last_item));
      lengths_owed <= owed_q.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
module tb;
  import lis_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEM_TARGET = 1200;
  localparam logic [VALUE_WIDTH-1:0] V_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [VALUE_WIDTH-1:0] V_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam longint LIM_HI = (longint'(1) << (VALUE_WIDTH - 1)) - 1;
  localparam longint LIM_LO = -LIM_HI - 1;

  typedef enum int {
    RUN_CLIMB, RUN_OVERFILL, RUN_SCATTER, RUN_FEW_VALUES, RUN_FALL, RUN_EXTREMES, RUN_SINGLE
  } run_kind_e;

  typedef enum int {RDY_ALWAYS, RDY_MOSTLY, RDY_RARELY, RDY_HOLDS} rdy_mode_e;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  int        mismatch_count;
  int        lengths_owed;
  int        cycle_count = 0;
  int        words_sent = 0;
  int        burst_left = 0;
  rdy_mode_e rdy_mode = RDY_ALWAYS;
  int        mode_left = 0;
  int        hold_left = 0;
  logic      hold_level = 1'b0;

  lis_in_if  in_w ();
  lis_out_if out_w ();

  lis_length_tail_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_w),
    .out_o  (out_w)
  );

  lis_length_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_mon         (in_w),
    .out_mon        (out_w),
    .mismatch_count (mismatch_count),
    .lengths_owed   (lengths_owed)
  );

  always #4 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: stall pattern picks a new random mode whenever the current one runs out
  initial begin
    out_w.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        rdy_mode  = rdy_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(40, 400);
      end
      mode_left--;
      case (rdy_mode)
        RDY_ALWAYS: out_w.ready <= 1'b1;
        RDY_MOSTLY: out_w.ready <= ($urandom_range(0, 9) < 7);
        RDY_RARELY: out_w.ready <= ($urandom_range(0, 9) < 2);
        default: begin
          // long holds off, short windows on
          if (hold_left == 0) begin
            hold_level = ~hold_level;
            hold_left  = hold_level ? $urandom_range(1, 8) : $urandom_range(1, 40);
          end
          hold_left--;
          out_w.ready <= hold_level;
        end
      endcase
    end
  end

  function automatic logic [VALUE_WIDTH-1:0] clamp_value(longint x);
    if (x > LIM_HI) return V_MAX;
    if (x < LIM_LO) return V_MIN;
    return x[VALUE_WIDTH-1:0];
  endfunction

  // Offer one word and hold it until taken
  task automatic send_word(logic [VALUE_WIDTH-1:0] v, logic closes);
    in_w.valid     <= 1'b1;
    in_w.value     <= v;
    in_w.last_item <= closes;
    @(posedge clk_i);
    while (!in_w.ready) @(posedge clk_i);
    words_sent++;
  endtask

  // Sender gap, with junk on the payload
  task automatic idle_for(int n);
    in_w.valid     <= 1'b0;
    in_w.value     <= $urandom();
    in_w.last_item <= 1'($urandom_range(0, 1));
    repeat (n) @(posedge clk_i);
  endtask

  // Bursts of random length, some with no gap in front
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) idle_for(gap);
    end
    burst_left--;
  endtask

  task automatic wait_drained();
    in_w.valid <= 1'b0;
    @(posedge clk_i);
    while (lengths_owed != 0) @(posedge clk_i);
  endtask

  // One sequence of n words, last word flagged
  task automatic run_sequence(run_kind_e kind, int n);
    longint                 cur;
    int                     r;
    logic [VALUE_WIDTH-1:0] v;
    case (kind)
      RUN_OVERFILL: cur = LIM_LO + $urandom_range(0, 1000);
      RUN_FALL:     cur = LIM_HI - $urandom_range(0, 1 << 24);
      default:      cur = LIM_LO + longint'($urandom());
    endcase
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      case (kind)
        RUN_CLIMB: begin
          if (r < 75) cur += $urandom_range(1, 1 << 24);
          else if (r >= 85) cur -= $urandom_range(0, 1 << 25);
          v = clamp_value(cur);
        end
        RUN_OVERFILL: begin
          if (r < 92) cur += $urandom_range(1, 1 << 23);
          else if (r >= 96) cur -= $urandom_range(0, 1 << 22);
          v = clamp_value(cur);
        end
        RUN_SCATTER: v = $urandom();
        RUN_FEW_VALUES: v = clamp_value(longint'($urandom_range(0, 7)) - 3);
        RUN_FALL: begin
          cur -= $urandom_range(0, 1 << 26);
          v = clamp_value(cur);
        end
        RUN_EXTREMES: begin
          case ($urandom_range(0, 5))
            0:       v = V_MIN;
            1:       v = V_MAX;
            2:       v = V_MIN + 1'b1;
            3:       v = V_MAX - 1'b1;
            4:       v = '1;
            default: v = '0;
          endcase
        end
        default: v = $urandom();
      endcase
      pace();
      send_word(v, i == n - 1);
    end
  endtask

  initial begin
    int        r;
    run_kind_e kind;
    int        n;
    rst_ni         <= 1'b0;
    in_w.valid     <= 1'b0;
    in_w.value     <= '0;
    in_w.last_item <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes and equal values: MIN after MAX sits on an equal tail
    send_word(V_MIN, 1'b0);
    send_word(V_MAX, 1'b0);
    send_word(V_MIN, 1'b0);
    send_word(V_MAX, 1'b0);
    send_word('0, 1'b0);
    send_word('1, 1'b0);
    send_word(VALUE_WIDTH'(5), 1'b0);
    send_word(VALUE_WIDTH'(5), 1'b0);
    send_word(VALUE_WIDTH'(3), 1'b1);
    // one-word sequence
    send_word(V_MAX, 1'b1);
    // falling run ends at the bottom of the range
    send_word(VALUE_WIDTH'(10), 1'b0);
    send_word(VALUE_WIDTH'(9), 1'b0);
    send_word(VALUE_WIDTH'(8), 1'b0);
    send_word(V_MIN, 1'b1);
    // rising run
    for (int i = 1; i <= 6; i++) send_word(VALUE_WIDTH'(i), i == 6);
    wait_drained();

    // Table full: run past the depth so overflow sets and clears at the end
    run_sequence(RUN_OVERFILL, $urandom_range(290, 300));

    while (words_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 3 && words_sent + 300 < ITEM_TARGET) begin
        kind = RUN_OVERFILL;
        n    = $urandom_range(290, 300);
      end else if (r < 40) begin
        kind = RUN_CLIMB;
        n    = $urandom_range(5, 60);
      end else if (r < 55) begin
        kind = RUN_SCATTER;
        n    = $urandom_range(1, 40);
      end else if (r < 67) begin
        kind = RUN_FEW_VALUES;
        n    = $urandom_range(1, 40);
      end else if (r < 77) begin
        kind = RUN_FALL;
        n    = $urandom_range(1, 30);
      end else if (r < 89) begin
        kind = RUN_EXTREMES;
        n    = $urandom_range(1, 20);
      end else begin
        kind = RUN_SINGLE;
        n    = 1;
      end
      run_sequence(kind, n);
      if ($urandom_range(0, 11) == 0) wait_drained();
    end

    wait_drained();
    repeat (30) @(posedge clk_i);
    if (mismatch_count == 0 && lengths_owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
